// ----- design/scsa_pkg.sv -----
// ----------------------------------------------------------------------------
// Size-class slab allocator package
// Widths, status and operation codes, the command bundle and the reset
// values of the class size registers.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int SIZE_W       = 26;
  localparam int TOTAL_W      = 30;
  localparam int CLASS_FW     = 3;
  localparam int SLOT_FW      = 6;
  localparam int STATUS_W     = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 30;

  // Register map of the configuration channel.
  localparam int                    CFG_CLASS_REGS = 6;
  localparam logic [CFG_IDX_W-1:0]  CFG_LIMIT_IDX  = 3'd6;

  localparam logic [TOTAL_W-1:0] LIMIT_RESET = 30'd512000000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = {TOTAL_W{1'b1}};

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OVER_LIMIT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE   = 3'd4;

  // Request type codes.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Operation held between the decide and the commit cycle.
  localparam logic [1:0] OP_ERR   = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  typedef struct packed {
    logic load;    // item accepted: decide and read the memories
    logic commit;  // write back state and load the result register
  } scsa_cmd_t;

  function automatic logic [SIZE_W-1:0] class_size_reset(input int c);
    logic [SIZE_W-1:0] v;
    case (c)
      0:       v = 26'd16;
      1:       v = 26'd243;
      2:       v = 26'd4096;
      3:       v = 26'd78125;
      4:       v = 26'd1679616;
      5:       v = 26'd40353607;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- design/scsa_if.sv -----
// ----------------------------------------------------------------------------
// Size-class slab allocator channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface scsa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [scsa_pkg::SIZE_W-1:0]  req_size;
  logic [scsa_pkg::CLASS_FW-1:0] free_class;
  logic [scsa_pkg::SLOT_FW-1:0] free_slot;

  modport source (output valid, req_type, req_size, free_class, free_slot, input ready);
  modport sink   (input valid, req_type, req_size, free_class, free_slot, output ready);
endinterface

interface scsa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [scsa_pkg::STATUS_W-1:0]  status;
  logic [scsa_pkg::CLASS_FW-1:0]  granted_class;
  logic [scsa_pkg::SLOT_FW-1:0]   granted_slot;
  logic [scsa_pkg::TOTAL_W-1:0]   total_allocated;

  modport source (output valid, status, granted_class, granted_slot, total_allocated,
                  input ready);
  modport sink   (input valid, status, granted_class, granted_slot, total_allocated,
                  output ready);
endinterface

interface scsa_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [scsa_pkg::CFG_IDX_W-1:0]   index;
  logic [scsa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/scsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Size-class slab allocator controller
// Two-state sequencer: accept an item, then commit it once the result
// register is free. Owns the handshakes of both item channels.
// ----------------------------------------------------------------------------
module scsa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output scsa_pkg::scsa_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign req_ready_o = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || rsp_ready_i;

  always_comb begin
    cmd_o.load   = req_valid_i && req_ready_o;
    cmd_o.commit = (state_q == ST_EXEC) && out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (cmd_o.commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_valid_o = out_valid_q;

  a_no_load_and_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.commit))
    else $error("load and commit in the same cycle");

  a_rsp_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("result appeared without an item in flight");

  a_rsp_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o)
    else $error("result item dropped before it was taken");

endmodule

// ----- design/scsa_dp.sv -----
// ----------------------------------------------------------------------------
// Size-class slab allocator datapath
// Class size and limit registers, per-class stack depth and low-water mark,
// the free stack and in-use memories, the running total and the result
// register.
// ----------------------------------------------------------------------------
module scsa_dp #(
  parameter int SIZE_CLASSES    = 6,
  parameter int SLOTS_PER_CLASS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  scsa_pkg::scsa_cmd_t              cmd_i,
  input  logic                             req_type_i,
  input  logic [scsa_pkg::SIZE_W-1:0]      req_size_i,
  input  logic [scsa_pkg::CLASS_FW-1:0]    free_class_i,
  input  logic [scsa_pkg::SLOT_FW-1:0]     free_slot_i,
  input  logic                             cfg_we_i,
  input  logic [scsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [scsa_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic [scsa_pkg::STATUS_W-1:0]    status_o,
  output logic [scsa_pkg::CLASS_FW-1:0]    granted_class_o,
  output logic [scsa_pkg::SLOT_FW-1:0]     granted_slot_o,
  output logic [scsa_pkg::TOTAL_W-1:0]     total_allocated_o
);

  localparam int CLS_IW    = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int SLOT_IW   = $clog2(SLOTS_PER_CLASS);
  localparam int DEP_W     = $clog2(SLOTS_PER_CLASS + 1);
  localparam int ADDR_W    = CLS_IW + SLOT_IW;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam logic [DEP_W-1:0] DEP_FULL = DEP_W'(SLOTS_PER_CLASS);

  localparam int SIZE_W  = scsa_pkg::SIZE_W;
  localparam int TOTAL_W = scsa_pkg::TOTAL_W;

  // Configuration registers.
  logic [SIZE_W-1:0]  class_size_q [SIZE_CLASSES];
  logic [TOTAL_W-1:0] limit_q;

  // Per-class stack depth and lowest depth reached since reset. Stack
  // positions and slots below the low-water mark have never been touched,
  // so they read as their reset contents without a clearing pass.
  logic [DEP_W-1:0]   depth_q [SIZE_CLASSES];
  logic [DEP_W-1:0]   lw_q    [SIZE_CLASSES];
  logic [TOTAL_W-1:0] total_q;

  logic [SLOT_IW-1:0] stk_mem  [MEM_DEPTH];
  logic               busy_mem [MEM_DEPTH];
  logic [SLOT_IW-1:0] stk_rdata_q;
  logic               busy_rdata_q;

  // Operation held from the decide cycle to the commit cycle.
  logic [1:0]                       op_q;
  logic [scsa_pkg::STATUS_W-1:0]    err_status_q;
  logic [scsa_pkg::CLASS_FW-1:0]    cls_q;
  logic [CLS_IW-1:0]                cls_idx_q;
  logic [scsa_pkg::SLOT_FW-1:0]     slot_q;
  logic [SIZE_W-1:0]                size_q;
  logic                             hit_q;

  // Decide cycle.
  logic                             fit_found;
  logic [CLS_IW-1:0]                fit_idx;
  logic                             over_limit;
  logic [DEP_W-1:0]                 alloc_depth;
  logic [DEP_W-1:0]                 pop_pos;
  logic                             f_in_range;
  logic [CLS_IW-1:0]                f_idx;
  logic [DEP_W-1:0]                 f_depth;
  logic                             free_ok;
  logic [ADDR_W-1:0]                stk_raddr;
  logic [ADDR_W-1:0]                busy_raddr;
  logic [1:0]                       op_d;
  logic [scsa_pkg::STATUS_W-1:0]    err_status_d;
  logic [scsa_pkg::CLASS_FW-1:0]    cls_d;
  logic [CLS_IW-1:0]                cls_idx_d;
  logic [scsa_pkg::SLOT_FW-1:0]     slot_d;
  logic [SIZE_W-1:0]                size_d;
  logic                             hit_d;

  // Commit cycle.
  logic [SLOT_IW-1:0]               alloc_slot;
  logic                             free_good;
  logic [TOTAL_W:0]                 sum_total;
  logic [TOTAL_W-1:0]               add_total;
  logic [TOTAL_W-1:0]               sub_total;
  logic [DEP_W-1:0]                 cur_depth;
  logic [scsa_pkg::STATUS_W-1:0]    res_status;
  logic [scsa_pkg::SLOT_FW-1:0]     res_slot;
  logic [TOTAL_W-1:0]               res_total;

  // First class whose chunk size is strictly greater than the request.
  always_comb begin
    fit_found = 1'b0;
    fit_idx   = '0;
    for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
      if (req_size_i < class_size_q[c]) begin
        fit_found = 1'b1;
        fit_idx   = CLS_IW'(c);
      end
    end
  end

  assign over_limit  = ({1'b0, total_q} + (TOTAL_W + 1)'(req_size_i)) > {1'b0, limit_q};
  assign alloc_depth = depth_q[fit_idx];
  assign pop_pos     = alloc_depth - DEP_W'(1);

  assign f_in_range = (int'(free_class_i) < SIZE_CLASSES)
                   && (int'(free_slot_i) < SLOTS_PER_CLASS);
  assign f_idx      = f_in_range ? free_class_i[CLS_IW-1:0] : '0;
  assign f_depth    = depth_q[f_idx];
  assign free_ok    = f_in_range && (f_depth < DEP_FULL);

  assign stk_raddr  = {fit_idx, pop_pos[SLOT_IW-1:0]};
  assign busy_raddr = {f_idx, free_slot_i[SLOT_IW-1:0]};

  always_comb begin
    op_d         = scsa_pkg::OP_ERR;
    err_status_d = scsa_pkg::ST_OK;
    cls_d        = '0;
    cls_idx_d    = fit_idx;
    slot_d       = '0;
    size_d       = class_size_q[fit_idx];
    hit_d        = alloc_depth > lw_q[fit_idx];
    if (req_type_i == scsa_pkg::REQ_ALLOC) begin
      if (!fit_found) begin
        err_status_d = scsa_pkg::ST_NO_FIT;
      end else if (over_limit) begin
        err_status_d = scsa_pkg::ST_OVER_LIMIT;
        cls_d        = scsa_pkg::CLASS_FW'(fit_idx);
      end else if (alloc_depth == '0) begin
        err_status_d = scsa_pkg::ST_FULL;
        cls_d        = scsa_pkg::CLASS_FW'(fit_idx);
      end else begin
        op_d   = scsa_pkg::OP_ALLOC;
        cls_d  = scsa_pkg::CLASS_FW'(fit_idx);
        // Untouched stack position: its slot equals the position.
        slot_d = scsa_pkg::SLOT_FW'(pop_pos);
      end
    end else begin
      op_d         = free_ok ? scsa_pkg::OP_FREE : scsa_pkg::OP_ERR;
      err_status_d = scsa_pkg::ST_BAD_FREE;
      cls_d        = free_class_i;
      cls_idx_d    = f_idx;
      slot_d       = free_slot_i;
      size_d       = class_size_q[f_idx];
      hit_d        = int'(free_slot_i) >= int'(lw_q[f_idx]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= op_d;
      err_status_q <= err_status_d;
      cls_q        <= cls_d;
      cls_idx_q    <= cls_idx_d;
      slot_q       <= slot_d;
      size_q       <= size_d;
      hit_q        <= hit_d;
    end
  end

  // Commit cycle: resolve the result from the registered memory reads.
  assign cur_depth  = depth_q[cls_idx_q];
  assign alloc_slot = hit_q ? stk_rdata_q : slot_q[SLOT_IW-1:0];
  assign free_good  = hit_q && busy_rdata_q;
  assign sum_total  = {1'b0, total_q} + (TOTAL_W + 1)'(size_q);
  assign add_total  = sum_total[TOTAL_W] ? scsa_pkg::TOTAL_MAX : sum_total[TOTAL_W-1:0];
  assign sub_total  = (total_q >= TOTAL_W'(size_q)) ? (total_q - TOTAL_W'(size_q)) : '0;

  always_comb begin
    res_status = err_status_q;
    res_slot   = slot_q;
    res_total  = total_q;
    case (op_q)
      scsa_pkg::OP_ALLOC: begin
        res_status = scsa_pkg::ST_OK;
        res_slot   = scsa_pkg::SLOT_FW'(alloc_slot);
        res_total  = add_total;
      end
      scsa_pkg::OP_FREE: begin
        if (free_good) begin
          res_status = scsa_pkg::ST_OK;
          res_total  = sub_total;
        end
      end
      default: begin
        res_status = err_status_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        class_size_q[c] <= scsa_pkg::class_size_reset(c);
      end
      limit_q <= scsa_pkg::LIMIT_RESET;
    end else if (cfg_we_i) begin
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        if (c < scsa_pkg::CFG_CLASS_REGS && int'(cfg_index_i) == c) begin
          class_size_q[c] <= cfg_data_i[SIZE_W-1:0];
        end
      end
      if (cfg_index_i == scsa_pkg::CFG_LIMIT_IDX) begin
        limit_q <= cfg_data_i[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        depth_q[c] <= DEP_FULL;
        lw_q[c]    <= DEP_FULL;
      end
      total_q <= '0;
    end else if (cmd_i.commit) begin
      if (op_q == scsa_pkg::OP_ALLOC) begin
        depth_q[cls_idx_q] <= cur_depth - DEP_W'(1);
        if ((cur_depth - DEP_W'(1)) < lw_q[cls_idx_q]) begin
          lw_q[cls_idx_q] <= cur_depth - DEP_W'(1);
        end
      end else if (op_q == scsa_pkg::OP_FREE && free_good) begin
        depth_q[cls_idx_q] <= cur_depth + DEP_W'(1);
      end
      total_q <= res_total;
    end
  end

  // Free stack memory: popped on allocation, pushed on a good free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      stk_rdata_q <= stk_mem[stk_raddr];
    end
    if (cmd_i.commit && op_q == scsa_pkg::OP_FREE && free_good) begin
      stk_mem[{cls_idx_q, cur_depth[SLOT_IW-1:0]}] <= slot_q[SLOT_IW-1:0];
    end
  end

  // In-use memory: set on allocation, read and cleared on free.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      busy_rdata_q <= busy_mem[busy_raddr];
    end
    if (cmd_i.commit && op_q == scsa_pkg::OP_ALLOC) begin
      busy_mem[{cls_idx_q, alloc_slot}] <= 1'b1;
    end else if (cmd_i.commit && op_q == scsa_pkg::OP_FREE && free_good) begin
      busy_mem[{cls_idx_q, slot_q[SLOT_IW-1:0]}] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_o          <= res_status;
      granted_class_o   <= cls_q;
      granted_slot_o    <= res_slot;
      total_allocated_o <= res_total;
    end
  end

  a_alloc_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_q == scsa_pkg::OP_ALLOC) |-> (cur_depth != '0))
    else $error("allocation committed on an empty class stack");

  a_free_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && op_q == scsa_pkg::OP_FREE) |-> (cur_depth < DEP_FULL))
    else $error("free committed on a full class stack");

  for (genvar i = 0; i < SIZE_CLASSES; i++) begin : g_lw_chk
    a_lw_below_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (lw_q[i] <= depth_q[i]) && (depth_q[i] <= DEP_FULL))
      else $error("low-water mark above stack depth");
  end

endmodule

// ----- design/size_class_slab_allocator.sv -----
// ----------------------------------------------------------------------------
// Size-class slab allocator
// Allocates and frees fixed-size chunks from per-class LIFO free stacks.
// ----------------------------------------------------------------------------
// Each request item is an allocation or a free and gives exactly one result
// item. In the decide step the block picks the class, checks the memory
// limit and stack depth and reads the free stack and in-use memory; in the
// commit step it updates the in-use memory, pushes a good free onto the
// free stack, updates the running total and loads the result register. A
// new item is not accepted until the current one has committed, and a
// pending result that is not taken holds the commit step. Memory contents
// need no clearing after reset: a per-class low-water mark tells which stack
// positions and slots still hold their reset values, so the block takes
// items as soon as reset is released. Configuration writes are always
// accepted and must only be issued while no item is in flight.
module size_class_slab_allocator #(
  parameter int SIZE_CLASSES    = 6,
  parameter int SLOTS_PER_CLASS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  scsa_req_if.sink   req_i,
  scsa_rsp_if.source rsp_o,
  scsa_cfg_if.sink   cfg_i
);

  scsa_pkg::scsa_cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  scsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  scsa_dp #(
    .SIZE_CLASSES    (SIZE_CLASSES),
    .SLOTS_PER_CLASS (SLOTS_PER_CLASS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .req_type_i        (req_i.req_type),
    .req_size_i        (req_i.req_size),
    .free_class_i      (req_i.free_class),
    .free_slot_i       (req_i.free_slot),
    .cfg_we_i          (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .status_o          (rsp_o.status),
    .granted_class_o   (rsp_o.granted_class),
    .granted_slot_o    (rsp_o.granted_slot),
    .total_allocated_o (rsp_o.total_allocated)
  );

endmodule

// ----- tb/scsa_checker.sv -----
// ----------------------------------------------------------------------------
// Slab allocator result checker
// Watches the request, response and register write channels. It keeps its
// own copy of the free stacks, in-use bits, running total and registers,
// predicts one result per accepted request item and compares every accepted
// result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module scsa_checker #(
  parameter int SIZE_CLASSES    = 6,
  parameter int SLOTS_PER_CLASS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  scsa_req_if  req_i,
  scsa_rsp_if  rsp_i,
  scsa_cfg_if  cfg_i,
  output int   pending_o,
  output int   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_W   = scsa_pkg::SIZE_W;
  localparam int TOTAL_W  = scsa_pkg::TOTAL_W;
  localparam int CLASS_FW = scsa_pkg::CLASS_FW;
  localparam int SLOT_FW  = scsa_pkg::SLOT_FW;
  localparam int STATUS_W = scsa_pkg::STATUS_W;

  typedef struct packed {
    logic                kind;
    logic [SIZE_W-1:0]   size;
    logic [CLASS_FW-1:0] cls;
    logic [SLOT_FW-1:0]  slot;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CLASS_FW-1:0] cls;
    logic [SLOT_FW-1:0]  slot;
    logic [TOTAL_W-1:0]  total;
  } grant_t;

  logic [SIZE_W-1:0]  class_bytes [SIZE_CLASSES];
  logic [TOTAL_W-1:0] mem_limit;
  logic [SLOT_FW-1:0] free_slots [SIZE_CLASSES][SLOTS_PER_CLASS];
  int                 free_count [SIZE_CLASSES];
  logic               in_use     [SIZE_CLASSES][SLOTS_PER_CLASS];
  logic [TOTAL_W-1:0] bytes_out;

  grant_t grants_due [$];
  int     mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic grant_t predict_grant(input request_t r);
    grant_t           g;
    int               c;
    int               chosen;
    logic [TOTAL_W:0] sum;
    g = '{status: scsa_pkg::ST_OK, cls: '0, slot: '0, total: '0};
    if (r.kind == scsa_pkg::REQ_ALLOC) begin
      chosen = -1;
      for (c = 0; c < SIZE_CLASSES; c++) begin
        if (chosen < 0 && r.size < class_bytes[c]) chosen = c;
      end
      sum = bytes_out + r.size;
      if (chosen < 0) begin
        g.status = scsa_pkg::ST_NO_FIT;
      end else if (sum > mem_limit) begin
        // The limit is checked against the request, not the chunk size.
        g.status = scsa_pkg::ST_OVER_LIMIT;
        g.cls    = CLASS_FW'(chosen);
      end else if (free_count[chosen] == 0) begin
        g.status = scsa_pkg::ST_FULL;
        g.cls    = CLASS_FW'(chosen);
      end else begin
        free_count[chosen]--;
        g.cls  = CLASS_FW'(chosen);
        g.slot = free_slots[chosen][free_count[chosen]];
        in_use[chosen][g.slot] = 1'b1;
        sum = bytes_out + class_bytes[chosen];
        bytes_out = (sum > scsa_pkg::TOTAL_MAX) ? scsa_pkg::TOTAL_MAX : sum[TOTAL_W-1:0];
      end
    end else begin
      g.cls  = r.cls;
      g.slot = r.slot;
      if (r.cls >= SIZE_CLASSES || r.slot >= SLOTS_PER_CLASS ||
          !in_use[r.cls][r.slot] || free_count[r.cls] >= SLOTS_PER_CLASS) begin
        g.status = scsa_pkg::ST_BAD_FREE;
      end else begin
        in_use[r.cls][r.slot] = 1'b0;
        free_slots[r.cls][free_count[r.cls]] = r.slot;
        free_count[r.cls]++;
        // A class size rewritten while chunks are out can exceed the total.
        if (bytes_out >= class_bytes[r.cls]) bytes_out = bytes_out - class_bytes[r.cls];
        else bytes_out = '0;
      end
    end
    g.total = bytes_out;
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    grant_t   got;
    grant_t   want;
    request_t r;
    int       c;
    int       k;
    if (!rst_ni) begin
      for (c = 0; c < SIZE_CLASSES; c++) begin
        case (c)
          0:       class_bytes[c] = 26'd16;
          1:       class_bytes[c] = 26'd243;
          2:       class_bytes[c] = 26'd4096;
          3:       class_bytes[c] = 26'd78125;
          4:       class_bytes[c] = 26'd1679616;
          5:       class_bytes[c] = 26'd40353607;
          default: class_bytes[c] = '0;
        endcase
        free_count[c] = SLOTS_PER_CLASS;
        for (k = 0; k < SLOTS_PER_CLASS; k++) begin
          free_slots[c][k] = SLOT_FW'(k);
          in_use[c][k]     = 1'b0;
        end
      end
      mem_limit = scsa_pkg::LIMIT_RESET;
      bytes_out = '0;
      grants_due.delete();
      pending_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index < scsa_pkg::CFG_CLASS_REGS) begin
          if (cfg_i.index < SIZE_CLASSES) class_bytes[cfg_i.index] = cfg_i.data[SIZE_W-1:0];
        end else if (cfg_i.index == scsa_pkg::CFG_LIMIT_IDX) begin
          mem_limit = cfg_i.data[TOTAL_W-1:0];
        end
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{status: rsp_i.status, cls: rsp_i.granted_class,
                slot: rsp_i.granted_slot, total: rsp_i.total_allocated};
        if (grants_due.size() == 0) begin
          mismatches++;
          $error("result item with no request outstanding: status %0d class %0d slot %0d",
                 got.status, got.cls, got.slot);
        end else begin
          want = grants_due.pop_front();
          if (got.status != want.status) begin
            mismatches++;
            $error("status: expected %0d, actual %0d", want.status, got.status);
          end
          if (got.cls != want.cls) begin
            mismatches++;
            $error("granted_class: expected %0d, actual %0d", want.cls, got.cls);
          end
          if (got.slot != want.slot) begin
            mismatches++;
            $error("granted_slot: expected %0d, actual %0d", want.slot, got.slot);
          end
          if (got.total != want.total) begin
            mismatches++;
            $error("total_allocated: expected %0d, actual %0d", want.total, got.total);
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        r = '{kind: req_i.req_type, size: req_i.req_size,
              cls: req_i.free_class, slot: req_i.free_slot};
        grants_due.push_back(predict_grant(r));
      end
      pending_o <= grants_due.size();
    end
  end

endmodule

// ----- tb/tb_size_class_slab_allocator.sv -----
// ----------------------------------------------------------------------------
// Slab allocator testbench
// Drives allocation and free requests and register writes into the block,
// with random idling on both channels, a long response hold-off and pauses
// that drain the block. A checker beside the block predicts and compares
// every result item; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_size_class_slab_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SIZE_W     = scsa_pkg::SIZE_W;
  localparam int CLASS_FW   = scsa_pkg::CLASS_FW;
  localparam int SLOT_FW    = scsa_pkg::SLOT_FW;
  localparam int CFG_IDX_W  = scsa_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = scsa_pkg::CFG_DATA_W;

  localparam int                   CLASSES     = 6;
  localparam int                   SLOTS       = 8;
  localparam int                   PHASES      = 7;
  localparam int                   PHASE_ITEMS = 240;
  localparam int                   HOLD_CYCLES = 150;
  localparam int                   SIZE_TOP    = (1 << SIZE_W) - 1;
  localparam logic [CFG_IDX_W-1:0] UNUSED_IDX  = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   fail_count;
  int   hold_asks = 0;
  logic stall_on  = 1'b1;

  // Shadow of the class sizes, used only to aim allocations at classes.
  logic [SIZE_W-1:0] cur_size [CLASSES];

  scsa_req_if req_ch ();
  scsa_rsp_if rsp_ch ();
  scsa_cfg_if cfg_ch ();

  size_class_slab_allocator #(
    .SIZE_CLASSES   (CLASSES),
    .SLOTS_PER_CLASS(SLOTS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch),
    .cfg_i (cfg_ch)
  );

  scsa_checker #(
    .SIZE_CLASSES   (CLASSES),
    .SLOTS_PER_CLASS(SLOTS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_i       (rsp_ch),
    .cfg_i       (cfg_ch),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("[size_class_slab_allocator] ERROR");
    $finish;
  end

  // Response side: random stalls, plus a long hold-off on request.
  initial begin : result_sink
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= !(stall_on && $urandom_range(99) < 19);
      end
    end
  end

  // Leaves valid high on return so that a following item keeps it up.
  task automatic put_request(input logic kind, input logic [SIZE_W-1:0] size,
                             input logic [CLASS_FW-1:0] cls, input logic [SLOT_FW-1:0] slot);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.req_size   <= size;
    req_ch.free_class <= cls;
    req_ch.free_slot  <= slot;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  task automatic idle_gap();
    if (stall_on && $urandom_range(99) < 19) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    if (idx < scsa_pkg::CFG_CLASS_REGS) cur_size[idx] = val[SIZE_W-1:0];
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic set_profile(input int p);
    logic [SIZE_W-1:0]     sz [CLASSES];
    logic [CFG_DATA_W-1:0] lim;
    int                    sorted [$];
    int                    c;
    case (p)
      0, 5: begin
        sz  = '{26'd16, 26'd243, 26'd4096, 26'd78125, 26'd1679616, 26'd40353607};
        lim = (p == 0) ? CFG_DATA_W'(scsa_pkg::LIMIT_RESET) : '0;
      end
      1: begin
        sz  = '{26'd1, 26'd2, 26'd3, 26'd4, 26'd5, 26'd6};
        lim = 30'd12;
      end
      2: begin
        // Huge chunks drive the total into saturation.
        for (c = 0; c < CLASSES; c++) sz[c] = SIZE_W'(SIZE_TOP - 3 * (CLASSES - 1 - c));
        lim = CFG_DATA_W'(scsa_pkg::TOTAL_MAX);
      end
      3: begin
        for (c = 0; c < CLASSES; c++) sorted.push_back($urandom_range(SIZE_TOP, 1));
        sorted.sort();
        for (c = 0; c < CLASSES; c++) sz[c] = SIZE_W'(sorted[c]);
        lim = CFG_DATA_W'($urandom);
      end
      4: begin
        for (c = 0; c < CLASSES; c++) begin
          if ($urandom_range(1) == 1) sz[c] = SIZE_W'($urandom_range(1000, 1));
          else sz[c] = SIZE_W'($urandom_range(SIZE_TOP, 1));
        end
        lim = CFG_DATA_W'($urandom_range(1_000_000_000, 0));
      end
      default: begin
        sz[0] = SIZE_W'(SIZE_TOP);
        for (c = 1; c < CLASSES; c++) sz[c] = 26'd1;
        lim = CFG_DATA_W'(scsa_pkg::TOTAL_MAX);
      end
    endcase
    // The bits above the class size field are random; the block drops them.
    for (c = 0; c < CLASSES; c++) write_reg(CFG_IDX_W'(c), {4'($urandom), sz[c]});
    write_reg(scsa_pkg::CFG_LIMIT_IDX, lim);
    if (p == 0) write_reg(UNUSED_IDX, CFG_DATA_W'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_request();
    int                c;
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    logic [SIZE_W-1:0] sz;
    if ($urandom_range(99) < 55) begin
      // Aim at one class: sizes between the previous class size and this one.
      c  = $urandom_range(CLASSES - 1);
      hi = cur_size[c] - 1'b1;
      lo = '0;
      if (c > 0) lo = cur_size[c-1];
      if (lo > hi) lo = '0;
      case ($urandom_range(9))
        0:       sz = SIZE_W'($urandom);
        1:       sz = cur_size[c];
        default: sz = SIZE_W'($urandom_range(hi, lo));
      endcase
      put_request(scsa_pkg::REQ_ALLOC, sz, CLASS_FW'($urandom), SLOT_FW'($urandom));
    end else if ($urandom_range(99) < 85) begin
      put_request(scsa_pkg::REQ_FREE, SIZE_W'($urandom),
                  CLASS_FW'($urandom_range(CLASSES - 1)),
                  SLOT_FW'($urandom_range(SLOTS - 1)));
    end else begin
      put_request(scsa_pkg::REQ_FREE, SIZE_W'($urandom), CLASS_FW'($urandom),
                  SLOT_FW'($urandom));
    end
  endtask

  initial begin : stimulus
    int p;
    int n;
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = scsa_pkg::REQ_ALLOC;
    req_ch.req_size   = '0;
    req_ch.free_class = '0;
    req_ch.free_slot  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    foreach (cur_size[i]) cur_size[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Class boundaries with the reset sizes; free-side fields are ignored here.
    put_request(scsa_pkg::REQ_ALLOC, 26'd0, '0, '0);
    put_request(scsa_pkg::REQ_ALLOC, 26'd15, '1, '1);
    put_request(scsa_pkg::REQ_ALLOC, 26'd16, '0, '0);
    put_request(scsa_pkg::REQ_ALLOC, 26'd40353606, '0, '0);
    put_request(scsa_pkg::REQ_ALLOC, 26'd40353607, '0, '0);
    put_request(scsa_pkg::REQ_ALLOC, '1, '0, '0);
    // A good free, the same free again, and frees out of range.
    put_request(scsa_pkg::REQ_FREE, '1, 3'd5, 6'd7);
    put_request(scsa_pkg::REQ_FREE, '0, 3'd5, 6'd7);
    put_request(scsa_pkg::REQ_FREE, '0, 3'd6, 6'd0);
    put_request(scsa_pkg::REQ_FREE, '0, 3'd7, 6'd63);
    put_request(scsa_pkg::REQ_FREE, '0, 3'd0, 6'd8);
    // Run the smallest class dry, then check that a freed slot comes back first.
    repeat (7) put_request(scsa_pkg::REQ_ALLOC, '0, '0, '0);
    put_request(scsa_pkg::REQ_FREE, '0, 3'd0, 6'd3);
    put_request(scsa_pkg::REQ_ALLOC, '0, '0, '0);
    wait_drained();
    write_reg(scsa_pkg::CFG_LIMIT_IDX, '0);
    cfg_ch.valid <= 1'b0;
    put_request(scsa_pkg::REQ_ALLOC, '0, '0, '0);
    put_request(scsa_pkg::REQ_FREE, '0, 3'd1, 6'd7);

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      stall_on = (p != 2);
      set_profile(p);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 30) hold_asks++;
        if (n == PHASE_ITEMS / 2) wait_drained();
        random_request();
        idle_gap();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[size_class_slab_allocator] OK");
    end else begin
      $display("[size_class_slab_allocator] ERROR");
    end
    $finish;
  end

endmodule
